>>> hdl/rolling_zscore_three_windows_macros.svh
// ---------------------------------------------------------------------------
// Rolling z-score assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ROLLING_ZSCORE_THREE_WINDOWS_MACROS_SVH
`define ROLLING_ZSCORE_THREE_WINDOWS_MACROS_SVH
`ifndef SYNTHESIS
`define RZS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RZS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RZS_ASSERT_SAME(label, ante, cons, msg)
`define RZS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/rzs_pkg.sv
// ---------------------------------------------------------------------------
// Rolling z-score package
// Shared types, codes and fixed widths for controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rzs_pkg;

  localparam int SAMPLE_PORT_W = 32;
  localparam int Z_W           = 16;
  localparam int ST_W          = 2;
  localparam int SCALE_SHIFT   = 16;
  localparam int DIGIT_W       = 8;
  localparam int QUO_W         = 32;
  localparam int ROOT_W        = 31;
  localparam int ROOT_STEPS    = 15;
  localparam int ROOT_TOP      = 2 * (ROOT_STEPS - 1);
  localparam int DRAIN_CYCLES  = 3;
  localparam int NUM_WIN       = 3;

  localparam logic [Z_W-1:0] Z_POS_MAX = 16'h7FFF;
  localparam logic [Z_W-1:0] Z_SAT_MAG = 16'h8000;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FULL = 2'd1,
    ST_ZERO_DEV = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,
    OP_READ,
    OP_PREP,
    OP_MUL,
    OP_QCALC,
    OP_ALOAD,
    OP_DIVINIT,
    OP_DIV,
    OP_SQINIT,
    OP_SQ,
    OP_FIN,
    OP_SKIP_FILL,
    OP_SKIP_ZERO,
    OP_COMMIT,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] win;
  } cmd_t;

  typedef struct packed {
    logic win_skip;
    logic q_zero;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/rzs_ctrl.sv
// ---------------------------------------------------------------------------
// Rolling z-score controller
// Sequences history walk, per-window multiply, divide and root steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rzs_ctrl #(
  parameter int LONG_WINDOW = 30,
  parameter int MUL_STEPS   = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  rzs_pkg::sts_t      sts,
  output rzs_pkg::cmd_t      cmd
);

  localparam int CNT_W = $clog2(LONG_WINDOW + rzs_pkg::QUO_W + MUL_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_DRAIN, S_PREP, S_MULQ, S_QCALC, S_CHKQ, S_MULD,
    S_DIVINIT, S_DIV, S_SQINIT, S_SQ, S_FIN, S_COMMIT, S_HOLD
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       win, win_next;
  logic             last_win;

  assign last_win = (win == 2'(rzs_pkg::NUM_WIN - 1));

  always_comb begin
    state_next = state;
    cnt_next   = (cnt == '0) ? '0 : cnt - 1'b1;
    win_next   = win;
    cmd.op     = rzs_pkg::OP_NONE;
    cmd.win    = win;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = rzs_pkg::OP_CAP;
          state_next = S_WALK;
          cnt_next   = CNT_W'(LONG_WINDOW - 1);
        end
      end
      S_WALK: begin
        cmd.op = rzs_pkg::OP_READ;
        if (cnt == '0) begin
          state_next = S_DRAIN;
          cnt_next   = CNT_W'(rzs_pkg::DRAIN_CYCLES - 1);
        end
      end
      S_DRAIN: begin
        if (cnt == '0) begin
          state_next = S_PREP;
          win_next   = '0;
        end
      end
      S_PREP: begin
        if (sts.win_skip) begin
          cmd.op = rzs_pkg::OP_SKIP_FILL;
          if (last_win) begin
            state_next = S_COMMIT;
          end else begin
            win_next = win + 1'b1;
          end
        end else begin
          cmd.op     = rzs_pkg::OP_PREP;
          state_next = S_MULQ;
          cnt_next   = CNT_W'(MUL_STEPS - 1);
        end
      end
      S_MULQ: begin
        cmd.op = rzs_pkg::OP_MUL;
        if (cnt == '0) begin
          state_next = S_QCALC;
        end
      end
      S_QCALC: begin
        cmd.op     = rzs_pkg::OP_QCALC;
        state_next = S_CHKQ;
      end
      S_CHKQ: begin
        if (sts.q_zero) begin
          cmd.op = rzs_pkg::OP_SKIP_ZERO;
          if (last_win) begin
            state_next = S_COMMIT;
          end else begin
            win_next   = win + 1'b1;
            state_next = S_PREP;
          end
        end else begin
          cmd.op     = rzs_pkg::OP_ALOAD;
          state_next = S_MULD;
          cnt_next   = CNT_W'(MUL_STEPS - 1);
        end
      end
      S_MULD: begin
        cmd.op = rzs_pkg::OP_MUL;
        if (cnt == '0) begin
          state_next = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd.op     = rzs_pkg::OP_DIVINIT;
        state_next = S_DIV;
        cnt_next   = CNT_W'(rzs_pkg::QUO_W - 1);
      end
      S_DIV: begin
        cmd.op = rzs_pkg::OP_DIV;
        if (cnt == '0) begin
          state_next = S_SQINIT;
        end
      end
      S_SQINIT: begin
        cmd.op     = rzs_pkg::OP_SQINIT;
        state_next = S_SQ;
        cnt_next   = CNT_W'(rzs_pkg::ROOT_STEPS - 1);
      end
      S_SQ: begin
        cmd.op = rzs_pkg::OP_SQ;
        if (cnt == '0) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op = rzs_pkg::OP_FIN;
        if (last_win) begin
          state_next = S_COMMIT;
        end else begin
          win_next   = win + 1'b1;
          state_next = S_PREP;
        end
      end
      S_COMMIT: begin
        cmd.op     = rzs_pkg::OP_COMMIT;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.op     = rzs_pkg::OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      win       <= '0;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      win      <= win_next;
      in_ready <= (state_next == S_IDLE);
      if (cmd.op == rzs_pkg::OP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/rzs_dp.sv
// ---------------------------------------------------------------------------
// Rolling z-score datapath
// History memory, window sums, digit multiplier, divider and root unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rzs_dp #(
  parameter int SHORT_WINDOW = 5,
  parameter int MID_WINDOW   = 10,
  parameter int LONG_WINDOW  = 30,
  parameter int SAMPLE_BITS  = 32,
  parameter int MUL_STEPS    = 5
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  rzs_pkg::cmd_t                             cmd,
  output rzs_pkg::sts_t                             sts,
  input  wire logic [rzs_pkg::SAMPLE_PORT_W-1:0]    sample,
  input  wire logic                                 restart,
  output logic signed [rzs_pkg::Z_W-1:0]            z_short,
  output logic signed [rzs_pkg::Z_W-1:0]            z_mid,
  output logic signed [rzs_pkg::Z_W-1:0]            z_long,
  output logic [rzs_pkg::ST_W-1:0]                  short_status,
  output logic [rzs_pkg::ST_W-1:0]                  mid_status,
  output logic [rzs_pkg::ST_W-1:0]                  long_status
);

  localparam int CW   = $clog2(LONG_WINDOW + 1);
  localparam int AW   = $clog2(LONG_WINDOW);
  localparam int OPW  = SAMPLE_BITS + CW;
  localparam int PW   = 2 * OPW;
  localparam int SQW  = 2 * SAMPLE_BITS + CW;
  localparam int AXW  = PW + CW;
  localparam int XW   = AXW + rzs_pkg::QUO_W;
  localparam int MBW  = MUL_STEPS * rzs_pkg::DIGIT_W;
  localparam int NW   = rzs_pkg::NUM_WIN;
  localparam int ZW   = rzs_pkg::Z_W;

  function automatic int win_len(input logic [1:0] idx);
    case (idx)
      2'd0:    win_len = SHORT_WINDOW;
      2'd1:    win_len = MID_WINDOW;
      default: win_len = LONG_WINDOW;
    endcase
  endfunction

  logic [SAMPLE_BITS-1:0] hist [LONG_WINDOW];
  logic [AW-1:0]          wslot, rptr, j, j1, j2;
  logic [CW-1:0]          fill;
  logic                   v1, v2;
  logic [SAMPLE_BITS-1:0] x, rdata, val2;
  logic [2*SAMPLE_BITS-1:0] sqr2;
  logic [OPW-1:0]         sum [NW];
  logic [SQW-1:0]         sq  [NW];

  logic [PW-1:0]          nsq, q, prod;
  logic [AXW-1:0]         a;
  logic [OPW-1:0]         mul_a, dmag;
  logic [MBW-1:0]         mul_b;
  logic                   dneg, ksat;
  logic [XW-1:0]          rem, dv;
  logic [rzs_pkg::QUO_W-1:0]  quo;
  logic [rzs_pkg::ROOT_W-1:0] num, root, rbit, trial;

  logic [ZW-1:0]          zw [NW];
  rzs_pkg::status_t       sw [NW];

  int                     n_int;
  logic [CW-1:0]          n_sel;
  logic [OPW-1:0]         sum_sel, nx, dmag_c;
  logic                   dneg_c;
  logic [ZW-1:0]          k, z_fin;

  assign n_int   = win_len(cmd.win);
  assign n_sel   = CW'(n_int);
  assign sum_sel = sum[cmd.win];
  assign nx      = OPW'(n_sel) * OPW'(x);
  assign dneg_c  = (nx < sum_sel);
  assign dmag_c  = dneg_c ? (sum_sel - nx) : (nx - sum_sel);
  assign trial   = root + rbit;
  assign k       = ksat ? rzs_pkg::Z_SAT_MAG : ZW'(root);
  assign z_fin   = dneg ? (ZW'(0) - k) : (ksat ? rzs_pkg::Z_POS_MAX : k);

  assign sts.win_skip = (n_int > LONG_WINDOW) || (int'(fill) < n_int);
  assign sts.q_zero   = (q == '0);

  always_ff @(posedge clk) begin
    if (cmd.op == rzs_pkg::OP_READ) begin
      rdata <= hist[rptr];
    end
    if (cmd.op == rzs_pkg::OP_COMMIT) begin
      hist[wslot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wslot <= '0;
      fill  <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= (cmd.op == rzs_pkg::OP_READ);
      v2 <= v1;
      if (cmd.op == rzs_pkg::OP_CAP && restart) begin
        fill <= '0;
      end
      if (cmd.op == rzs_pkg::OP_COMMIT) begin
        wslot <= (wslot == AW'(LONG_WINDOW - 1)) ? '0 : wslot + 1'b1;
        if (fill < CW'(LONG_WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    j1   <= j;
    j2   <= j1;
    val2 <= rdata;
    sqr2 <= (2*SAMPLE_BITS)'(rdata) * (2*SAMPLE_BITS)'(rdata);
    for (int i = 0; i < NW; i++) begin
      if (v2 && (int'(j2) < win_len(2'(i)))) begin
        sum[i] <= sum[i] + OPW'(val2);
        sq[i]  <= sq[i] + SQW'(sqr2);
      end
    end
    case (cmd.op)
      rzs_pkg::OP_CAP: begin
        x    <= sample[SAMPLE_BITS-1:0];
        j    <= '0;
        rptr <= (wslot == '0) ? AW'(LONG_WINDOW - 1) : wslot - 1'b1;
        for (int i = 0; i < NW; i++) begin
          sum[i] <= '0;
          sq[i]  <= '0;
        end
      end
      rzs_pkg::OP_READ: begin
        j    <= j + 1'b1;
        rptr <= (rptr == '0) ? AW'(LONG_WINDOW - 1) : rptr - 1'b1;
      end
      rzs_pkg::OP_PREP: begin
        nsq   <= PW'(n_sel) * PW'(sq[cmd.win]);
        mul_a <= sum_sel;
        mul_b <= MBW'(sum_sel);
        prod  <= '0;
        dmag  <= dmag_c;
        dneg  <= dneg_c;
      end
      rzs_pkg::OP_MUL: begin
        prod  <= (prod << rzs_pkg::DIGIT_W)
                 + PW'(mul_a) * PW'(mul_b[MBW-1 -: rzs_pkg::DIGIT_W]);
        mul_b <= mul_b << rzs_pkg::DIGIT_W;
      end
      rzs_pkg::OP_QCALC: begin
        q <= nsq - prod;
      end
      rzs_pkg::OP_ALOAD: begin
        a     <= AXW'(n_sel) * AXW'(q);
        mul_a <= dmag;
        mul_b <= MBW'(dmag);
        prod  <= '0;
      end
      rzs_pkg::OP_DIVINIT: begin
        rem <= (XW'(prod) * XW'(n_sel - 1'b1)) << rzs_pkg::SCALE_SHIFT;
        dv  <= XW'(a) << (rzs_pkg::QUO_W - 1);
        quo <= '0;
      end
      rzs_pkg::OP_DIV: begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[rzs_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[rzs_pkg::QUO_W-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      rzs_pkg::OP_SQINIT: begin
        ksat <= quo[rzs_pkg::QUO_W-1] | quo[rzs_pkg::QUO_W-2];
        num  <= rzs_pkg::ROOT_W'(quo[rzs_pkg::QUO_W-3:0]);
        root <= '0;
        rbit <= rzs_pkg::ROOT_W'(1) << rzs_pkg::ROOT_TOP;
      end
      rzs_pkg::OP_SQ: begin
        if (num >= trial) begin
          num  <= num - trial;
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
      end
      rzs_pkg::OP_FIN: begin
        zw[cmd.win] <= z_fin;
        sw[cmd.win] <= rzs_pkg::ST_OK;
      end
      rzs_pkg::OP_SKIP_FILL: begin
        zw[cmd.win] <= '0;
        sw[cmd.win] <= rzs_pkg::ST_NOT_FULL;
      end
      rzs_pkg::OP_SKIP_ZERO: begin
        zw[cmd.win] <= '0;
        sw[cmd.win] <= rzs_pkg::ST_ZERO_DEV;
      end
      rzs_pkg::OP_PUBLISH: begin
        z_short      <= zw[0];
        z_mid        <= zw[1];
        z_long       <= zw[2];
        short_status <= sw[0];
        mid_status   <= sw[1];
        long_status  <= sw[2];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/rolling_zscore_three_windows.sv
// ---------------------------------------------------------------------------
// Rolling z-score over three trailing windows
// One sample in, one result of three Q7.8 z-scores with status out.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry sample and restart; restart clears
// the fill count before the sample is scored. Output channel:
// out_valid/out_ready carry z_short, z_mid, z_long and their status codes
// (ok, history not full, zero deviation).
// Each item walks the history memory once (LONG_WINDOW reads, one a cycle)
// to build all window sums, then scores the windows one after another on a
// shared digit multiplier (MUL_STEPS digit steps per product), a restoring
// divider (32 quotient bits) and a bit-pair square root unit (15 steps);
// windows not yet full or with zero deviation end early.
// One item is in work at a time.
// The result sits in an output register: the next item is taken while it
// waits, and its own result is held back until the receiver has taken it.
// Reset clears the write slot, the fill count and both handshakes; history
// contents are not cleared; unwritten slots feed only windows marked not full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_zscore_three_windows_macros.svh"
module rolling_zscore_three_windows #(
  parameter int SHORT_WINDOW = 5,
  parameter int MID_WINDOW   = 10,
  parameter int LONG_WINDOW  = 30,
  parameter int SAMPLE_BITS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rzs_pkg::SAMPLE_PORT_W-1:0] sample,
  input  wire logic                              restart,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [rzs_pkg::Z_W-1:0]         z_short,
  output logic signed [rzs_pkg::Z_W-1:0]         z_mid,
  output logic signed [rzs_pkg::Z_W-1:0]         z_long,
  output logic [rzs_pkg::ST_W-1:0]               short_status,
  output logic [rzs_pkg::ST_W-1:0]               mid_status,
  output logic [rzs_pkg::ST_W-1:0]               long_status
);

  localparam int CW        = $clog2(LONG_WINDOW + 1);
  localparam int MUL_STEPS = (SAMPLE_BITS + CW + rzs_pkg::DIGIT_W - 1) / rzs_pkg::DIGIT_W;

  rzs_pkg::cmd_t cmd;
  rzs_pkg::sts_t sts;

  rzs_ctrl #(
    .LONG_WINDOW (LONG_WINDOW),
    .MUL_STEPS   (MUL_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rzs_dp #(
    .SHORT_WINDOW (SHORT_WINDOW),
    .MID_WINDOW   (MID_WINDOW),
    .LONG_WINDOW  (LONG_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MUL_STEPS    (MUL_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (sample),
    .restart      (restart),
    .z_short      (z_short),
    .z_mid        (z_mid),
    .z_long       (z_long),
    .short_status (short_status),
    .mid_status   (mid_status),
    .long_status  (long_status)
  );

  `RZS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")
  `RZS_ASSERT_NEXT(a_publish_valid, cmd.op == rzs_pkg::OP_PUBLISH, out_valid, "publish lost")
  `RZS_ASSERT_SAME(a_long_not_full_zero, out_valid && long_status == rzs_pkg::ST_NOT_FULL, z_long == '0, "z_long not zero")
  `RZS_ASSERT_SAME(a_mid_zero_dev_zero, out_valid && mid_status == rzs_pkg::ST_ZERO_DEV, z_mid == '0, "z_mid not zero")

endmodule
`default_nettype wire
